### sv/uasp_pkg.sv
// ----------------------------------------------------------------------------
// uasp_pkg: shared types and codes of the ustar archive stream parser
// Holds the word formats of both channels and the result and error codes.
// ----------------------------------------------------------------------------
package uasp_pkg;

    localparam int POS_W = 40;
    localparam int LEN_W = 40;
    localparam int SIZE_W = 36;
    localparam int MODE_W = 24;

    localparam logic [2:0] KIND_FILE = 3'd0;
    localparam logic [2:0] KIND_DIR = 3'd1;
    localparam logic [2:0] KIND_DATA = 3'd2;
    localparam logic [2:0] KIND_FINISH = 3'd3;
    localparam logic [2:0] KIND_ERROR = 3'd4;

    localparam logic [2:0] ERR_MAGIC = 3'd0;
    localparam logic [2:0] ERR_SIZE = 3'd1;
    localparam logic [2:0] ERR_MODE = 3'd2;
    localparam logic [2:0] ERR_TRUNC = 3'd3;
    localparam logic [2:0] ERR_PATH = 3'd4;

    localparam logic [1:0] PH_HEADER = 2'd0;
    localparam logic [1:0] PH_DATA = 2'd1;
    localparam logic [1:0] PH_DONE = 2'd2;

    localparam logic [1:0] OCT_SKIP = 2'd0;
    localparam logic [1:0] OCT_DIGITS = 2'd1;
    localparam logic [1:0] OCT_END = 2'd2;
    localparam logic [1:0] OCT_BAD = 2'd3;

    localparam logic [1:0] CL_OTHER = 2'd0;
    localparam logic [1:0] CL_DOT = 2'd1;
    localparam logic [1:0] CL_SLASH = 2'd2;

    typedef struct packed {
        logic [7:0] archive_byte;
        logic       start_of_archive;
    } in_word_t;

    typedef struct packed {
        logic [2:0]        result_kind;
        logic [SIZE_W-1:0] entry_size;
        logic              is_executable;
        logic [7:0]        file_byte;
        logic [2:0]        error_code;
        logic              last_of_run;
    } out_word_t;

    typedef struct packed {
        logic [1:0] count;
        out_word_t  first;
        out_word_t  second;
    } emit_t;

endpackage

### sv/uasp_front.sv
// ----------------------------------------------------------------------------
// uasp_front: byte classifier and header walker
// Takes one archive byte per accepted word and forms zero to two result words.
// ----------------------------------------------------------------------------
module uasp_front (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           accept,
    input  uasp_pkg::in_word_t             item,
    input  logic [uasp_pkg::LEN_W-1:0]     archive_length,
    output uasp_pkg::emit_t                emit
);

    typedef struct packed {
        logic            ended;
        logic [1:0]      len;
        logic [2:0][1:0] cls;
        logic [1:0]      run;
        logic            dd;
    } seg_t;

    logic [uasp_pkg::POS_W-1:0]  pos_reg, pos_next;
    logic [1:0]                  phase_reg, phase_next;
    logic                        zrun_reg, zrun_next;
    logic                        bz_reg, bz_next;
    logic                        nz_reg, nz_next;
    logic                        magic_reg, magic_next;
    logic [uasp_pkg::SIZE_W-1:0] size_reg, size_next;
    logic [1:0]                  sst_reg, sst_next;
    logic [uasp_pkg::MODE_W-1:0] mode_reg, mode_next;
    logic [1:0]                  mst_reg, mst_next;
    logic [7:0]                  type_reg, type_next;
    seg_t                        nseg_reg, nseg_next;
    seg_t                        pseg_reg, pseg_next;
    logic [uasp_pkg::LEN_W-1:0]  dleft_reg, dleft_next;
    logic [uasp_pkg::SIZE_W-1:0] fleft_reg, fleft_next;

    function automatic seg_t seg_feed(seg_t s, logic [7:0] b);
        seg_t r;
        logic [1:0] c;
        r = s;
        c = (b == 8'h2f) ? uasp_pkg::CL_SLASH : (b == 8'h2e) ? uasp_pkg::CL_DOT :
            uasp_pkg::CL_OTHER;
        if (!s.ended) begin
            if (b == 8'h00) begin
                r.ended = 1'b1;
            end else begin
                if (s.len < 2'd3) begin
                    r.cls[s.len] = c;
                    r.len = s.len + 2'd1;
                end
                if (b == 8'h2f) begin
                    if (s.run == 2'd2) r.dd = 1'b1;
                    r.run = 2'd0;
                end else if (b == 8'h2e) begin
                    r.run = (s.run == 2'd0) ? 2'd1 : (s.run == 2'd1) ? 2'd2 : 2'd3;
                end else begin
                    r.run = 2'd3;
                end
            end
        end
        return r;
    endfunction

    function automatic logic path_unsafe(seg_t p, seg_t nm);
        logic [2:0][1:0] pc;
        logic [2:0] n;
        logic strip;
        pc = '0;
        n = 3'd0;
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < p.len && n < 3'd3) begin
                pc[n[1:0]] = p.cls[i];
                n = n + 3'd1;
            end
        end
        if (p.len != 2'd0 && n < 3'd3) begin
            pc[n[1:0]] = uasp_pkg::CL_SLASH;
            n = n + 3'd1;
        end
        for (int i = 0; i < 3; i++) begin
            if (2'(i) < nm.len && n < 3'd3) begin
                pc[n[1:0]] = nm.cls[i];
                n = n + 3'd1;
            end
        end
        strip = n >= 3'd2 && pc[0] == uasp_pkg::CL_DOT && pc[1] == uasp_pkg::CL_SLASH;
        if ((p.len != 2'd0 && (p.dd || p.run == 2'd2)) || nm.dd || nm.run == 2'd2) begin
            return 1'b1;
        end
        if (strip) return n == 3'd2 || pc[2] == uasp_pkg::CL_SLASH;
        return n == 3'd0 || pc[0] == uasp_pkg::CL_SLASH;
    endfunction

    function automatic void oct_feed(inout logic [1:0] st, inout logic [35:0] acc,
                                     input logic [7:0] b);
        if (st != uasp_pkg::OCT_END && st != uasp_pkg::OCT_BAD &&
            !(st == uasp_pkg::OCT_SKIP && b == 8'h20)) begin
            if (b == 8'h20 || b == 8'h00) begin
                st = uasp_pkg::OCT_END;
            end else if (b < 8'h30 || b > 8'h37) begin
                st = uasp_pkg::OCT_BAD;
            end else begin
                acc = {acc[32:0], b[2:0]};
                st = uasp_pkg::OCT_DIGITS;
            end
        end
    endfunction

    function automatic uasp_pkg::out_word_t mk(logic [2:0] kind, logic [35:0] sz,
                                               logic exe, logic [7:0] fb, logic [2:0] err);
        uasp_pkg::out_word_t w;
        w.result_kind = kind;
        w.entry_size = sz;
        w.is_executable = exe;
        w.file_byte = fb;
        w.error_code = err;
        w.last_of_run = 1'b0;
        return w;
    endfunction

    function automatic logic fits(logic [39:0] base, logic [39:0] len);
        return len >= 40'd512 && base <= len - 40'd512;
    endfunction

    always_comb
    begin
        logic [8:0] off;
        logic [7:0] b;
        logic [39:0] nxt;
        logic [36:0] padded;
        logic [35:0] macc;
        logic regular;
        logic handled;
        logic stop;
        uasp_pkg::out_word_t w0, w1;
        logic [1:0] n;
        pos_next = pos_reg;
        phase_next = phase_reg;
        zrun_next = zrun_reg;
        bz_next = bz_reg;
        nz_next = nz_reg;
        magic_next = magic_reg;
        size_next = size_reg;
        sst_next = sst_reg;
        mode_next = mode_reg;
        mst_next = mst_reg;
        type_next = type_reg;
        nseg_next = nseg_reg;
        pseg_next = pseg_reg;
        dleft_next = dleft_reg;
        fleft_next = fleft_reg;
        b = item.archive_byte;
        w0 = mk(3'd0, 36'd0, 1'b0, 8'd0, 3'd0);
        w1 = w0;
        n = 2'd0;
        stop = 1'b0;
        padded = '0;
        macc = '0;
        if (item.start_of_archive) begin
            pos_next = '0;
            phase_next = uasp_pkg::PH_HEADER;
            zrun_next = 1'b0;
            dleft_next = '0;
            fleft_next = '0;
        end
        off = pos_next[8:0];
        nxt = pos_next + 40'd1;
        if (phase_next == uasp_pkg::PH_HEADER) begin
            if (off == 9'd0 || item.start_of_archive) begin
                bz_next = 1'b1;
                nz_next = 1'b1;
                magic_next = 1'b1;
                size_next = '0;
                sst_next = uasp_pkg::OCT_SKIP;
                mode_next = '0;
                mst_next = uasp_pkg::OCT_SKIP;
                type_next = '0;
                nseg_next = '0;
                pseg_next = '0;
            end
            if (off == 9'd0 && !fits(pos_next, archive_length)) begin
                w0 = mk(uasp_pkg::KIND_FINISH, 36'd0, 1'b0, 8'd0, 3'd0);
                n = 2'd1;
                phase_next = uasp_pkg::PH_DONE;
                stop = 1'b1;
            end
            if (!stop) begin
                if (b != 8'd0) begin
                    bz_next = 1'b0;
                    if (off < 9'd100) nz_next = 1'b0;
                end
                if (off < 9'd100) begin
                    nseg_next = seg_feed(nseg_next, b);
                end else if (off < 9'd108) begin
                    macc = {12'd0, mode_next};
                    oct_feed(mst_next, macc, b);
                    mode_next = macc[23:0];
                end else if (off >= 9'd124 && off < 9'd136) begin
                    oct_feed(sst_next, size_next, b);
                end else if (off == 9'd156) begin
                    type_next = b;
                end else if (off >= 9'd257 && off < 9'd262) begin
                    case (off)
                        9'd257: if (b != 8'h75) magic_next = 1'b0;
                        9'd258: if (b != 8'h73) magic_next = 1'b0;
                        9'd259: if (b != 8'h74) magic_next = 1'b0;
                        9'd260: if (b != 8'h61) magic_next = 1'b0;
                        default: if (b != 8'h72) magic_next = 1'b0;
                    endcase
                end else if (off >= 9'd345 && off < 9'd500) begin
                    pseg_next = seg_feed(pseg_next, b);
                end
                if (off == 9'd511) begin
                    regular = type_next == 8'h30 || type_next == 8'h00;
                    handled = regular || type_next == 8'h35;
                    padded = {1'b0, size_next} + 37'd511;
                    padded[8:0] = 9'd0;
                    if (bz_next) begin
                        if (zrun_next || !fits(nxt, archive_length)) begin
                            w0 = mk(uasp_pkg::KIND_FINISH, 36'd0, 1'b0, 8'd0, 3'd0);
                            n = 2'd1;
                            phase_next = uasp_pkg::PH_DONE;
                        end
                        zrun_next = 1'b1;
                    end else begin
                        zrun_next = 1'b0;
                        phase_next = uasp_pkg::PH_DONE;
                        n = 2'd1;
                        if (nz_next) begin
                            w0 = mk(uasp_pkg::KIND_FINISH, 36'd0, 1'b0, 8'd0, 3'd0);
                        end else if (!magic_next) begin
                            w0 = mk(uasp_pkg::KIND_ERROR, 36'd0, 1'b0, 8'd0,
                                    uasp_pkg::ERR_MAGIC);
                        end else if (sst_next == uasp_pkg::OCT_BAD) begin
                            w0 = mk(uasp_pkg::KIND_ERROR, 36'd0, 1'b0, 8'd0,
                                    uasp_pkg::ERR_SIZE);
                        end else if (mst_next == uasp_pkg::OCT_BAD) begin
                            w0 = mk(uasp_pkg::KIND_ERROR, 36'd0, 1'b0, 8'd0,
                                    uasp_pkg::ERR_MODE);
                        end else if (nxt > archive_length ||
                                     {3'd0, padded} > archive_length - nxt) begin
                            w0 = mk(uasp_pkg::KIND_ERROR, 36'd0, 1'b0, 8'd0,
                                    uasp_pkg::ERR_TRUNC);
                        end else if (handled && path_unsafe(pseg_next, nseg_next)) begin
                            w0 = mk(uasp_pkg::KIND_ERROR, 36'd0, 1'b0, 8'd0,
                                    uasp_pkg::ERR_PATH);
                        end else begin
                            phase_next = uasp_pkg::PH_HEADER;
                            n = 2'd0;
                            if (handled) begin
                                w0 = mk(regular ? uasp_pkg::KIND_FILE : uasp_pkg::KIND_DIR,
                                        size_next, (mode_next[0] | mode_next[3] | mode_next[6]),
                                        8'd0, 3'd0);
                                n = 2'd1;
                            end
                            if (padded == 37'd0) begin
                                if (!fits(nxt, archive_length)) begin
                                    phase_next = uasp_pkg::PH_DONE;
                                    if (handled) begin
                                        w1 = mk(uasp_pkg::KIND_FINISH, 36'd0, 1'b0, 8'd0,
                                                3'd0);
                                    end else begin
                                        w0 = mk(uasp_pkg::KIND_FINISH, 36'd0, 1'b0, 8'd0,
                                                3'd0);
                                    end
                                    n = n + 2'd1;
                                end
                            end else begin
                                phase_next = uasp_pkg::PH_DATA;
                                dleft_next = {3'd0, padded};
                                fleft_next = regular ? size_next : 36'd0;
                            end
                        end
                    end
                end
                pos_next = nxt;
            end
        end else if (phase_next == uasp_pkg::PH_DATA) begin
            if (fleft_next != '0) begin
                w0 = mk(uasp_pkg::KIND_DATA, 36'd0, 1'b0, b, 3'd0);
                n = 2'd1;
                fleft_next = fleft_next - 36'd1;
            end
            if (dleft_next != '0) dleft_next = dleft_next - 40'd1;
            if (dleft_next == '0) begin
                phase_next = uasp_pkg::PH_HEADER;
                fleft_next = '0;
                if (!fits(nxt, archive_length)) begin
                    phase_next = uasp_pkg::PH_DONE;
                    if (n == 2'd1) begin
                        w1 = mk(uasp_pkg::KIND_FINISH, 36'd0, 1'b0, 8'd0, 3'd0);
                    end else begin
                        w0 = mk(uasp_pkg::KIND_FINISH, 36'd0, 1'b0, 8'd0, 3'd0);
                    end
                    n = n + 2'd1;
                end
            end
            pos_next = nxt;
        end
        if (n == 2'd1) w0.last_of_run = 1'b1;
        if (n == 2'd2) w1.last_of_run = 1'b1;
        emit.count = accept ? n : 2'd0;
        emit.first = w0;
        emit.second = w1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            pos_reg <= '0;
            phase_reg <= uasp_pkg::PH_HEADER;
            zrun_reg <= 1'b0;
            bz_reg <= 1'b1;
            nz_reg <= 1'b1;
            magic_reg <= 1'b1;
            size_reg <= '0;
            sst_reg <= uasp_pkg::OCT_SKIP;
            mode_reg <= '0;
            mst_reg <= uasp_pkg::OCT_SKIP;
            type_reg <= '0;
            nseg_reg <= '0;
            pseg_reg <= '0;
            dleft_reg <= '0;
            fleft_reg <= '0;
        end else if (accept) begin
            pos_reg <= pos_next;
            phase_reg <= phase_next;
            zrun_reg <= zrun_next;
            bz_reg <= bz_next;
            nz_reg <= nz_next;
            magic_reg <= magic_next;
            size_reg <= size_next;
            sst_reg <= sst_next;
            mode_reg <= mode_next;
            mst_reg <= mst_next;
            type_reg <= type_next;
            nseg_reg <= nseg_next;
            pseg_reg <= pseg_next;
            dleft_reg <= dleft_next;
            fleft_reg <= fleft_next;
        end
    end

endmodule

### sv/uasp_queue.sv
// ----------------------------------------------------------------------------
// uasp_queue: result queue
// Takes up to two result words per cycle and hands them out one at a time.
// ----------------------------------------------------------------------------
module uasp_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  uasp_pkg::emit_t     emit,
    input  logic                pop,
    output logic                empty,
    output logic                nearly_full,
    output uasp_pkg::out_word_t result
);

    uasp_pkg::out_word_t mem [8];
    logic [2:0] wp_reg, wp_next;
    logic [2:0] rp_reg, rp_next;
    logic [3:0] cnt_reg, cnt_next;
    logic       take;

    assign empty = cnt_reg == 4'd0;
    assign nearly_full = cnt_reg > 4'd6;
    assign result = mem[rp_reg];
    assign take = pop && !empty;

    always_comb
    begin
        wp_next = wp_reg + 3'(emit.count);
        rp_next = rp_reg + 3'(take);
        cnt_next = cnt_reg + 4'(emit.count) - 4'(take);
    end

    always_ff @(posedge clk)
    begin
        if (emit.count != 2'd0) mem[wp_reg] <= emit.first;
        if (emit.count == 2'd2) mem[wp_reg + 3'd1] <= emit.second;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wp_reg <= '0;
            rp_reg <= '0;
            cnt_reg <= '0;
        end else begin
            wp_reg <= wp_next;
            rp_reg <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

endmodule

### sv/ustar_archive_stream_parser.sv
// ----------------------------------------------------------------------------
// ustar_archive_stream_parser: streaming ustar archive walker
// Checks headers, emits entry records, file data words, a finish or an error.
// ----------------------------------------------------------------------------
// Archive bytes enter as words on the push/full channel, one byte per word.
// Results leave on the empty/pop channel, oldest first; each byte yields zero
// to two result words, and last_of_run marks the final one of a byte.
// The archive length is written on the cfg_valid/cfg_ready channel, which is
// always ready; it resets to 512.
// A byte is classified in the cycle it is accepted and its results are in
// the eight-entry result queue in the next cycle.
// One byte is accepted per cycle while the queue has two free entries; the
// sustained rate is set by the pop rate, since data bytes give one result.
// When the receiver stalls the queue fills and full rises; nothing is lost.
// Reset clears the walk state and empties the queue. After a finish or an
// error, bytes are accepted and dropped until start_of_archive is set.
// ----------------------------------------------------------------------------
module ustar_archive_stream_parser (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    output logic                           full,
    input  uasp_pkg::in_word_t             item,
    output logic                           empty,
    input  logic                           pop,
    output uasp_pkg::out_word_t            result,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [uasp_pkg::LEN_W-1:0]     cfg_data
);

    logic [uasp_pkg::LEN_W-1:0] len_reg;
    logic                       accept;
    uasp_pkg::emit_t            emit;

    assign cfg_ready = 1'b1;
    assign accept = push && !full;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            len_reg <= 40'd512;
        end else if (cfg_valid) begin
            len_reg <= cfg_data;
        end
    end

    uasp_front u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .accept         (accept),
        .item           (item),
        .archive_length (len_reg),
        .emit           (emit)
    );

    uasp_queue u_queue (
        .clk         (clk),
        .rst_n       (rst_n),
        .emit        (emit),
        .pop         (pop),
        .empty       (empty),
        .nearly_full (full),
        .result      (result)
    );

endmodule
